### src/tpt_pkg.sv
// Package for the touch point tracker: sizes, register indexes, event and
// state codes, and the command/status structs between controller and datapath.
// No dependencies.
package tpt_pkg;

   localparam int MAX_POINTS = 10;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int ID_W       = 4;
   localparam int BYTE_W     = 8;
   localparam int COORD_W    = 12;
   localparam int SQ_W       = 2 * COORD_W;
   localparam int DIST_W     = SQ_W + 1;
   localparam int THR_W      = 25;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 25;

   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SWAP_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT  = 2'd2;

   localparam logic [THR_W-1:0]   THR_RESET    = 25'd64;
   localparam logic [COORD_W-1:0] HEIGHT_RESET = 12'hFFF;

   typedef enum logic [2:0] {
      EV_DOWN  = 3'd0,
      EV_MOVE  = 3'd1,
      EV_STILL = 3'd2,
      EV_UP    = 3'd3,
      EV_NONE  = 3'd4
   } event_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQR,
      ST_UPD,
      ST_END,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept_point;
      logic calc_diff;
      logic calc_sq;
      logic update_point;
      logic end_mark;
      logic clear_frame;
      logic idx_clear;
      logic idx_inc;
      logic emit_load;
   } cmd_type;

   typedef struct packed {
      logic pt_ok;
      logic abort;
      logic change_any;
      logic entry_pending;
      logic idx_final;
      logic out_free;
   } status_type;

endpackage

### src/tpt_channels.sv
// Valid/ready channel interfaces for point/frame requests and event responses.
// Depends on tpt_pkg.
interface tpt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       cmd;
   logic [tpt_pkg::BYTE_W-1:0] x_high;
   logic [tpt_pkg::BYTE_W-1:0] x_low;
   logic [tpt_pkg::BYTE_W-1:0] y_high;
   logic [tpt_pkg::BYTE_W-1:0] y_low;

   modport source (output valid, cmd, x_high, x_low, y_high, y_low, input ready);
   modport sink   (input valid, cmd, x_high, x_low, y_high, y_low, output ready);
endinterface

interface tpt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tpt_pkg::ID_W-1:0]    contact_id;
   logic [1:0]                  event_kind;
   logic [tpt_pkg::COORD_W-1:0] pos_x;
   logic [tpt_pkg::COORD_W-1:0] pos_y;
   logic                        last;

   modport source (output valid, contact_id, event_kind, pos_x, pos_y, last, input ready);
   modport sink   (input valid, contact_id, event_kind, pos_x, pos_y, last, output ready);
endinterface

### src/tpt_ctrl.sv
// Controller FSM: sequences point classification, end-of-frame marking and
// event emission. Depends on tpt_pkg.
module tpt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_is_end,
   output logic                req_ready,
   input  tpt_pkg::status_type status,
   output tpt_pkg::cmd_type    cmd
);

   tpt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tpt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == tpt_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         tpt_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_is_end) begin
                  state_in = tpt_pkg::ST_END;
               end else begin
                  cmd.accept_point = 1'b1;
                  if (status.pt_ok) begin
                     state_in = tpt_pkg::ST_DIFF;
                  end
               end
            end
         end
         tpt_pkg::ST_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = tpt_pkg::ST_SQR;
         end
         tpt_pkg::ST_SQR: begin
            cmd.calc_sq = 1'b1;
            state_in    = tpt_pkg::ST_UPD;
         end
         tpt_pkg::ST_UPD: begin
            cmd.update_point = 1'b1;
            state_in         = tpt_pkg::ST_IDLE;
         end
         tpt_pkg::ST_END: begin
            if (status.abort) begin
               cmd.clear_frame = 1'b1;
               state_in        = tpt_pkg::ST_IDLE;
            end else begin
               cmd.end_mark = 1'b1;
               if (status.change_any) begin
                  cmd.idx_clear = 1'b1;
                  state_in      = tpt_pkg::ST_EMIT;
               end else begin
                  cmd.clear_frame = 1'b1;
                  state_in        = tpt_pkg::ST_IDLE;
               end
            end
         end
         tpt_pkg::ST_EMIT: begin
            if (!status.entry_pending || status.out_free) begin
               cmd.emit_load = status.entry_pending;
               if (status.idx_final) begin
                  cmd.clear_frame = 1'b1;
                  state_in        = tpt_pkg::ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = tpt_pkg::ST_IDLE;
         end
      endcase
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> status.out_free && status.entry_pending)
      else $error("event loaded into a busy output register");

   a_point_seq: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tpt_pkg::ST_UPD) |->
         ($past(state_ff) == tpt_pkg::ST_SQR && $past(state_ff, 2) == tpt_pkg::ST_DIFF))
      else $error("point update reached without diff and square steps");

endmodule

### src/tpt_datapath.sv
// Datapath: coordinate decode and rotation, per-id position and event store,
// distance check, frame bookkeeping and the response register. Depends on tpt_pkg.
module tpt_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wen,
   input  logic [tpt_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tpt_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [tpt_pkg::BYTE_W-1:0]      req_x_high,
   input  logic [tpt_pkg::BYTE_W-1:0]      req_x_low,
   input  logic [tpt_pkg::BYTE_W-1:0]      req_y_high,
   input  logic [tpt_pkg::BYTE_W-1:0]      req_y_low,
   input  tpt_pkg::cmd_type                cmd,
   output tpt_pkg::status_type             status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tpt_pkg::ID_W-1:0]        rsp_contact_id,
   output logic [1:0]                      rsp_event_kind,
   output logic [tpt_pkg::COORD_W-1:0]     rsp_pos_x,
   output logic [tpt_pkg::COORD_W-1:0]     rsp_pos_y,
   output logic                            rsp_last
);

   localparam int MAXP = tpt_pkg::MAX_POINTS;
   localparam int IW   = tpt_pkg::IDX_W;
   localparam int CW   = tpt_pkg::COORD_W;

   // configuration
   logic [tpt_pkg::THR_W-1:0] thr_ff;
   logic                      swap_ff;
   logic [CW-1:0]             height_ff;

   // frame state
   logic [MAXP-1:0]      known_ff, seen_ff;
   logic                 change_ff, abort_ff;
   logic [CW-1:0]        last_x_ff [MAXP];
   logic [CW-1:0]        last_y_ff [MAXP];
   tpt_pkg::event_type   pend_ff [MAXP];
   logic [IW-1:0]        idx_ff;

   // point pipeline
   logic [CW-1:0]            cur_x_ff, cur_y_ff, dx_ff, dy_ff;
   logic [IW-1:0]            cur_id_ff;
   logic [tpt_pkg::SQ_W-1:0] sqx_ff, sqy_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [tpt_pkg::ID_W-1:0] rsp_id_ff;
   logic [1:0]          rsp_kind_ff;
   logic [CW-1:0]       rsp_x_ff, rsp_y_ff;
   logic                rsp_last_ff;

   logic [CW-1:0]              x_raw, y_raw, x_dec, y_dec, y_rot;
   logic [tpt_pkg::ID_W-1:0]   id_raw;
   logic [CW-1:0]              lx, ly;
   logic [tpt_pkg::DIST_W-1:0] sq_sum;
   tpt_pkg::event_type         pt_event;
   logic [MAXP-1:0]            released, pend_mask, above_mask;

   // decode and optional rotation
   assign x_raw  = {req_x_high[3:0], req_x_low};
   assign y_raw  = {req_y_high[3:0], req_y_low};
   assign id_raw = req_y_high[7:4];
   assign y_rot  = (x_raw > height_ff) ? '0 : height_ff - x_raw;
   assign x_dec  = swap_ff ? y_raw : x_raw;
   assign y_dec  = swap_ff ? y_rot : y_raw;

   assign lx     = last_x_ff[cur_id_ff];
   assign ly     = last_y_ff[cur_id_ff];
   assign sq_sum = tpt_pkg::DIST_W'(sqx_ff) + tpt_pkg::DIST_W'(sqy_ff);

   always_comb begin
      if (!known_ff[cur_id_ff]) begin
         pt_event = tpt_pkg::EV_DOWN;
      end else if (sq_sum > tpt_pkg::DIST_W'(thr_ff)) begin
         pt_event = tpt_pkg::EV_MOVE;
      end else begin
         pt_event = tpt_pkg::EV_STILL;
      end
   end

   assign released = known_ff & ~seen_ff;

   always_comb begin
      for (int i = 0; i < MAXP; i++) begin
         pend_mask[i]  = (pend_ff[i] != tpt_pkg::EV_NONE);
         above_mask[i] = (IW'(i) > idx_ff);
      end
   end

   assign status.pt_ok         = !abort_ff &&
                                 ({1'b0, id_raw} < (tpt_pkg::ID_W + 1)'(MAXP));
   assign status.abort         = abort_ff;
   assign status.change_any    = change_ff || (|released);
   assign status.entry_pending = pend_mask[idx_ff];
   assign status.idx_final     = (idx_ff == IW'(MAXP - 1));
   assign status.out_free      = !rsp_valid_ff || rsp_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= tpt_pkg::THR_RESET;
         swap_ff   <= 1'b0;
         height_ff <= tpt_pkg::HEIGHT_RESET;
      end else if (csr_wen) begin
         case (csr_index)
            tpt_pkg::CSR_MOVE_THRESHOLD: thr_ff    <= csr_wdata[tpt_pkg::THR_W-1:0];
            tpt_pkg::CSR_SWAP_MODE:      swap_ff   <= csr_wdata[0];
            tpt_pkg::CSR_SCREEN_HEIGHT:  height_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   // point pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.accept_point && status.pt_ok) begin
         cur_x_ff  <= x_dec;
         cur_y_ff  <= y_dec;
         cur_id_ff <= id_raw[IW-1:0];
      end
      if (cmd.calc_diff) begin
         dx_ff <= (lx > cur_x_ff) ? lx - cur_x_ff : cur_x_ff - lx;
         dy_ff <= (ly > cur_y_ff) ? ly - cur_y_ff : cur_y_ff - ly;
      end
      if (cmd.calc_sq) begin
         sqx_ff <= tpt_pkg::SQ_W'(dx_ff) * tpt_pkg::SQ_W'(dx_ff);
         sqy_ff <= tpt_pkg::SQ_W'(dy_ff) * tpt_pkg::SQ_W'(dy_ff);
      end
   end

   // frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         seen_ff   <= '0;
         change_ff <= 1'b0;
         abort_ff  <= 1'b0;
         idx_ff    <= '0;
         for (int i = 0; i < MAXP; i++) begin
            last_x_ff[i] <= '0;
            last_y_ff[i] <= '0;
            pend_ff[i]   <= tpt_pkg::EV_NONE;
         end
      end else begin
         if (cmd.accept_point && !status.pt_ok) begin
            abort_ff <= 1'b1;
         end
         if (cmd.update_point) begin
            last_x_ff[cur_id_ff] <= cur_x_ff;
            last_y_ff[cur_id_ff] <= cur_y_ff;
            pend_ff[cur_id_ff]   <= pt_event;
            seen_ff[cur_id_ff]   <= 1'b1;
            if (pt_event != tpt_pkg::EV_STILL) begin
               change_ff <= 1'b1;
            end
         end
         if (cmd.end_mark) begin
            known_ff <= seen_ff;
         end
         if (cmd.clear_frame) begin
            seen_ff   <= '0;
            change_ff <= 1'b0;
            abort_ff  <= 1'b0;
            for (int i = 0; i < MAXP; i++) begin
               pend_ff[i] <= tpt_pkg::EV_NONE;
            end
         end else if (cmd.end_mark) begin
            for (int i = 0; i < MAXP; i++) begin
               if (released[i]) begin
                  pend_ff[i] <= tpt_pkg::EV_UP;
               end
            end
         end
         if (cmd.idx_clear) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // response register
   always_comb begin
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         rsp_id_ff   <= tpt_pkg::ID_W'(idx_ff);
         rsp_kind_ff <= pend_ff[idx_ff][1:0];
         rsp_x_ff    <= last_x_ff[idx_ff];
         rsp_y_ff    <= last_y_ff[idx_ff];
         rsp_last_ff <= ((pend_mask & above_mask) == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_contact_id = rsp_id_ff;
   assign rsp_event_kind = rsp_kind_ff;
   assign rsp_pos_x      = rsp_x_ff;
   assign rsp_pos_y      = rsp_y_ff;
   assign rsp_last       = rsp_last_ff;

   a_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_frame |=> (seen_ff == '0 && !change_ff && !abort_ff))
      else $error("frame state not cleared");

   a_abort_src: assert property (@(posedge clock) disable iff (reset)
      $rose(abort_ff) |-> $past(cmd.accept_point))
      else $error("abort raised without a point transfer");

endmodule

### src/touch_point_tracker.sv
// Top level of the touch point tracker: channel interfaces, configuration
// port, controller and datapath. Depends on tpt_pkg, tpt_channels, tpt_ctrl, tpt_datapath.
//
// A point transfer steps through accept, difference, square, and classify and store;
// a point with an out-of-range id, or any point after one, ends at the accept step.
// An end-of-frame transfer with nothing to report ends at the end-of-frame step;
// otherwise that step is followed by the id-order walk of the event store, which
// waits whenever the response register is stalled while holding an event.
// The single-entry response register lets the next request be taken while the last
// event of a frame still waits on the response side. Configuration writes land at
// once and are meant to be made only while the block is idle.
module touch_point_tracker (
   input  logic                           clock,
   input  logic                           reset,
   tpt_req_if.sink                        req_ch,
   tpt_rsp_if.source                      rsp_ch,
   input  logic                           csr_wen,
   input  logic [tpt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tpt_pkg::CSR_DATA_W-1:0] csr_wdata
);

   tpt_pkg::cmd_type    cmd;
   tpt_pkg::status_type status;

   tpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_is_end (req_ch.cmd),
      .req_ready  (req_ch.ready),
      .status     (status),
      .cmd        (cmd)
   );

   tpt_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_x_high     (req_ch.x_high),
      .req_x_low      (req_ch.x_low),
      .req_y_high     (req_ch.y_high),
      .req_y_low      (req_ch.y_low),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_contact_id (rsp_ch.contact_id),
      .rsp_event_kind (rsp_ch.event_kind),
      .rsp_pos_x      (rsp_ch.pos_x),
      .rsp_pos_y      (rsp_ch.pos_y),
      .rsp_last       (rsp_ch.last)
   );

endmodule
